// File: hw/rtl/first_fit_heap_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core_defines
// Assertion macros used by the allocator datapath. Each macro samples on clk
// and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication: cond must hold whenever trig holds.
`define FFHA_ASSERT_IMPL(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("allocator assertion failed");

// Next-cycle implication: cond must hold in the cycle after trig.
`define FFHA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("allocator assertion failed");

`endif

// File: hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types, sizes and codes shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES   = 2 * 1024 * 1024;
    localparam int HEADER_BYTES = 12;
    localparam int MAX_BLOCKS   = 256;

    localparam int REQ_W  = 21;
    localparam int OFF_W  = 21;
    localparam int STAT_W = 2;

    localparam int START_W = $clog2(HEAP_BYTES);
    localparam int TOP_W   = $clog2(HEAP_BYTES + 1);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int END_W   = ((TOP_W > REQ_W) ? TOP_W : REQ_W) + 2;

    localparam int IN_DATA_W  = ((REQ_W + OFF_W + 7) / 8) * 8;
    localparam int OUT_FLD_W  = STAT_W + OFF_W + REQ_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef logic [START_W-1:0] start_t;
    typedef logic [REQ_W-1:0]   size_t;
    typedef logic [OFF_W-1:0]   off_t;
    typedef logic [TOP_W-1:0]   top_t;
    typedef logic [END_W-1:0]   end_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NULL    = 2'd1,
        STATUS_SPACE   = 2'd2,
        STATUS_UNKNOWN = 2'd3
    } status_t;

    typedef struct packed {
        start_t start;
        size_t  size;
        logic   is_free;
    } entry_t;

    typedef enum logic [2:0] {
        FIN_REJECT,
        FIN_REUSE,
        FIN_APPEND,
        FIN_FREE_HIT,
        FIN_UNKNOWN
    } fin_kind_t;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_SCAN,
        CTRL_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic      start;
        logic      scan;
        logic      finish;
        fin_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic in_reject;
        logic op_free;
        logic hit;
        logic exhausted;
        logic out_free;
    } stat_t;

endpackage

// File: hw/rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: block table memory, scan pipeline, heap pointer,
// block count and output register.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_defines.svh"

module ffha_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ffha_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [ffha_pkg::OUT_DATA_W-1:0] m_tdata,
    input  ffha_pkg::cmd_t                  cmd,
    output ffha_pkg::stat_t                 stat
);

    ffha_pkg::entry_t table_mem [ffha_pkg::MAX_BLOCKS];

    logic               op_free_reg;
    ffha_pkg::size_t    req_reg;
    ffha_pkg::off_t     off_reg;
    ffha_pkg::cnt_t     idx_reg, idx_next;
    logic               rvalid_reg, rvalid_next;
    ffha_pkg::entry_t   rd_entry_reg;
    ffha_pkg::idx_t     rd_idx_reg;
    ffha_pkg::cnt_t     count_reg, count_next;
    ffha_pkg::top_t     top_reg, top_next;
    logic               m_tvalid_reg, m_tvalid_next;
    ffha_pkg::status_t  out_status_reg, out_status_next;
    ffha_pkg::off_t     out_payload_reg, out_payload_next;
    ffha_pkg::size_t    out_granted_reg, out_granted_next;

    ffha_pkg::size_t    in_req;
    ffha_pkg::off_t     in_off;
    logic               match;
    logic               hit;
    logic               rd_en;
    logic               space_ok;
    logic               is_last;
    ffha_pkg::end_t     end_sum;
    ffha_pkg::end_t     slot_payload;
    ffha_pkg::end_t     hit_payload;
    ffha_pkg::end_t     drop;
    logic               wr_en;
    ffha_pkg::idx_t     wr_addr;
    ffha_pkg::entry_t   wr_entry;

    assign in_req = s_tdata[ffha_pkg::REQ_W-1:0];
    assign in_off = s_tdata[ffha_pkg::REQ_W+ffha_pkg::OFF_W-1:ffha_pkg::REQ_W];

    assign hit_payload  = ffha_pkg::end_t'(rd_entry_reg.start)
                        + ffha_pkg::end_t'(ffha_pkg::HEADER_BYTES);
    assign slot_payload = ffha_pkg::end_t'(top_reg) + ffha_pkg::end_t'(ffha_pkg::HEADER_BYTES);
    assign end_sum      = slot_payload + ffha_pkg::end_t'(req_reg);
    assign drop         = ffha_pkg::end_t'(ffha_pkg::HEADER_BYTES)
                        + ffha_pkg::end_t'(rd_entry_reg.size);

    assign match = op_free_reg ? (hit_payload == ffha_pkg::end_t'(off_reg))
                               : (rd_entry_reg.is_free && (rd_entry_reg.size >= req_reg));
    assign hit   = rvalid_reg && match;
    assign rd_en = cmd.scan && (idx_reg < count_reg) && !hit;

    assign space_ok = (count_reg < ffha_pkg::cnt_t'(ffha_pkg::MAX_BLOCKS))
                   && (end_sum <= ffha_pkg::end_t'(ffha_pkg::HEAP_BYTES));
    assign is_last  = (ffha_pkg::cnt_t'(rd_idx_reg) + ffha_pkg::cnt_t'(1)) == count_reg;

    assign stat.in_reject = (s_tuser == ffha_pkg::FUNC_FREE) ? (in_off == '0) : (in_req == '0);
    assign stat.op_free   = op_free_reg;
    assign stat.hit       = hit;
    assign stat.exhausted = !rvalid_reg && (idx_reg >= count_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Scan pipeline: one table read per cycle, the registered word checked
    // in the following cycle.
    always_comb
    begin
        idx_next    = idx_reg;
        rvalid_next = rvalid_reg;
        if (cmd.start)
        begin
            idx_next    = '0;
            rvalid_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            rvalid_next = rd_en;
            if (rd_en)
            begin
                idx_next = idx_reg + ffha_pkg::cnt_t'(1);
            end
        end
    end

    always_comb
    begin
        wr_en            = 1'b0;
        wr_addr          = rd_idx_reg;
        wr_entry         = rd_entry_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        out_status_next  = out_status_reg;
        out_payload_next = out_payload_reg;
        out_granted_next = out_granted_reg;
        if (cmd.finish)
        begin
            m_tvalid_next    = 1'b1;
            out_status_next  = ffha_pkg::STATUS_OK;
            out_payload_next = '0;
            out_granted_next = '0;
            case (cmd.kind)
                ffha_pkg::FIN_REJECT:
                begin
                    out_status_next = ffha_pkg::STATUS_NULL;
                end
                ffha_pkg::FIN_REUSE:
                begin
                    wr_en            = 1'b1;
                    wr_entry.is_free = 1'b0;
                    out_payload_next = hit_payload[ffha_pkg::OFF_W-1:0];
                    out_granted_next = rd_entry_reg.size;
                end
                ffha_pkg::FIN_APPEND:
                begin
                    if (space_ok)
                    begin
                        wr_en            = 1'b1;
                        wr_addr          = count_reg[ffha_pkg::IDX_W-1:0];
                        wr_entry.start   = top_reg[ffha_pkg::START_W-1:0];
                        wr_entry.size    = req_reg;
                        wr_entry.is_free = 1'b0;
                        count_next       = count_reg + ffha_pkg::cnt_t'(1);
                        top_next         = ffha_pkg::top_t'(end_sum);
                        out_payload_next = slot_payload[ffha_pkg::OFF_W-1:0];
                        out_granted_next = req_reg;
                    end
                    else
                    begin
                        out_status_next = ffha_pkg::STATUS_SPACE;
                    end
                end
                ffha_pkg::FIN_FREE_HIT:
                begin
                    if (is_last)
                    begin
                        count_next = count_reg - ffha_pkg::cnt_t'(1);
                        top_next   = (drop > ffha_pkg::end_t'(top_reg)) ? '0
                                   : ffha_pkg::top_t'(ffha_pkg::end_t'(top_reg) - drop);
                    end
                    else
                    begin
                        wr_en            = 1'b1;
                        wr_entry.is_free = 1'b1;
                    end
                end
                ffha_pkg::FIN_UNKNOWN:
                begin
                    out_status_next = ffha_pkg::STATUS_UNKNOWN;
                end
                default:
                begin
                    out_status_next = ffha_pkg::STATUS_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= table_mem[idx_reg[ffha_pkg::IDX_W-1:0]];
            rd_idx_reg   <= idx_reg[ffha_pkg::IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_free_reg <= s_tuser;
            req_reg     <= in_req;
            off_reg     <= in_off;
        end
        out_status_reg  <= out_status_next;
        out_payload_reg <= out_payload_next;
        out_granted_reg <= out_granted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rvalid_reg   <= 1'b0;
            count_reg    <= '0;
            top_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            rvalid_reg   <= rvalid_next;
            count_reg    <= count_next;
            top_reg      <= top_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{ffha_pkg::OUT_PAD_W{1'b0}}, out_granted_reg, out_payload_reg,
                       out_status_reg};

    `FFHA_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= ffha_pkg::cnt_t'(ffha_pkg::MAX_BLOCKS))
    `FFHA_ASSERT_IMPL(a_top_bound, 1'b1, top_reg <= ffha_pkg::top_t'(ffha_pkg::HEAP_BYTES))
    `FFHA_ASSERT_IMPL(a_read_in_range, rd_en, idx_reg < count_reg)
    `FFHA_ASSERT_NEXT(a_finish_shows, cmd.finish, m_tvalid_reg)
    `FFHA_ASSERT_NEXT(a_append_grows, cmd.finish && (cmd.kind == ffha_pkg::FIN_APPEND) && space_ok, count_reg == $past(count_reg) + ffha_pkg::cnt_t'(1))

endmodule

// File: hw/rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Allocator controller: accepts an item, runs the table scan and picks the
// closing action for the datapath.
// ----------------------------------------------------------------------------
module ffha_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  ffha_pkg::stat_t stat,
    output ffha_pkg::cmd_t  cmd
);

    ffha_pkg::ctrl_state_t state_reg, state_next;
    ffha_pkg::fin_kind_t   kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::CTRL_IDLE;
            kind_reg  <= ffha_pkg::FIN_REJECT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        s_tready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.finish = 1'b0;
        cmd.kind   = kind_reg;
        case (state_reg)
            ffha_pkg::CTRL_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start = 1'b1;
                    if (stat.in_reject)
                    begin
                        kind_next  = ffha_pkg::FIN_REJECT;
                        state_next = ffha_pkg::CTRL_FINISH;
                    end
                    else
                    begin
                        state_next = ffha_pkg::CTRL_SCAN;
                    end
                end
            end
            ffha_pkg::CTRL_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                begin
                    kind_next  = stat.op_free ? ffha_pkg::FIN_FREE_HIT : ffha_pkg::FIN_REUSE;
                    state_next = ffha_pkg::CTRL_FINISH;
                end
                else if (stat.exhausted)
                begin
                    kind_next  = stat.op_free ? ffha_pkg::FIN_UNKNOWN : ffha_pkg::FIN_APPEND;
                    state_next = ffha_pkg::CTRL_FINISH;
                end
            end
            ffha_pkg::CTRL_FINISH:
            begin
                // Hold until the output register can take the result.
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ffha_pkg::CTRL_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::CTRL_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator over a table of up to MAX_BLOCKS blocks.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken while the controller is idle, then
// the block table is scanned from entry 0 one entry per cycle through the
// single read port of the table memory, stopping at the first match. A
// zero-size allocate or null free goes from accept straight to finish;
// any other item passes accept, the scan of the valid entries, the check
// of each read entry and finish. The result sits in an output register,
// so a new item is taken while the previous result waits.
//
// Allocate (tuser = 0) reuses the first free block big enough, unsplit and
// keeping its recorded size; failing that, it appends a block of header
// plus request at the top of the heap, or reports out of space when the
// heap or the table is full. Free (tuser = 1) of the last block pops it and
// lowers the top; any other known block is only marked free. No clearing
// pass is needed after reset: only entries below the block count are read.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [20:0] request_bytes, [41:21] block_offset, [47:42] zero
    input  logic [ffha_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] func: 0 allocate, 1 free
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [22:2] payload_offset, [43:23] granted_bytes, [47:44] zero
    output logic [ffha_pkg::OUT_DATA_W-1:0] m_tdata
);

    ffha_pkg::cmd_t  cmd;
    ffha_pkg::stat_t stat;

    // Sequence accept, scan and finish.
    ffha_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the table, heap top, block count and the result register.
    ffha_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule
